// ===== design/gml_pkg.sv =====
// ============================================================================
// gml_pkg
// Shared types and constants of the Gaussian mixture likelihood scorer.
// ============================================================================
package gml_pkg;

    typedef struct packed {
        logic               mode;
        logic [2:0]         component;
        logic [3:0]         dimension;
        logic signed [15:0] mean_value;
        logic [31:0]        inverse_variance;
        logic [31:0]        mix_weight;
        logic signed [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [63:0] likelihood;
        logic        overflow;
    } out_item_t;

    localparam logic [1:0]  REG_GAUSSIANS = 2'd0;
    localparam logic [1:0]  REG_DIMS      = 2'd1;
    localparam logic [47:0] DIST_MAX      = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] LOG2E_Q24     = 32'h0171_5476;
    localparam logic [31:0] LN2_Q32       = 32'hB172_17F8;
    localparam int          TAYLOR_DEGREE = 12;

    typedef struct packed {
        logic        start;
        logic [31:0] weight;
        logic [47:0] distance;
    } exp_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] term;
    } exp_rsp_t;

endpackage

// ===== design/gaussian_mixture_likelihood.sv =====
// ============================================================================
// gaussian_mixture_likelihood
// Diagonal-covariance Gaussian mixture scorer with load and sample items.
// ============================================================================
// A load item passes through the load state. A sample item steps through a
// read, multiply and accumulate state per Gaussian in use, through one shared
// 32x34 multiply and accumulate; the closing sample then runs the exp unit
// once per Gaussian (a zero term, skipping the series, when the distance is past
// the cutoff, else two multiplies in each of the 12 series steps) and posts the
// result. in_ready is low while an item is in work; a finished result waits in the output register.
module gaussian_mixture_likelihood #(
    parameter int MAX_COMPONENTS = 8,
    parameter int MAX_DIMS       = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gml_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gml_pkg::out_item_t   out_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [4:0]           cfg_data
);

    localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int AW = CW + DW;
    localparam int NW = $clog2(MAX_COMPONENTS + 1);
    localparam int EW = $clog2(MAX_DIMS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_READ  = 8'b00000010,
        S_MUL   = 8'b00000100,
        S_ACC   = 8'b00001000,
        S_EXP   = 8'b00010000,
        S_WAIT  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_LOAD  = 8'b10000000
    } state_t;

    state_t        state_reg, state_next;
    logic [3:0]    gcfg_reg;
    logic [4:0]    dcfg_reg;
    logic [EW-1:0] count_reg;
    logic [NW-1:0] comp_reg;
    gml_pkg::in_item_t item_reg;
    logic [47:0]   dist_reg [MAX_COMPONENTS];
    logic [MAX_COMPONENTS-1:0] sat_reg;
    logic [15:0]   mean_mem [MAX_COMPONENTS*MAX_DIMS];
    logic [31:0]   ivar_mem [MAX_COMPONENTS*MAX_DIMS];
    logic [31:0]   wt_mem   [MAX_COMPONENTS];
    logic [15:0]   mean_rd;
    logic [31:0]   ivar_rd;
    logic [31:0]   wt_rd;
    logic [33:0]   sq_reg;
    logic [63:0]   sum_reg;
    logic          ovf_reg;
    logic          out_valid_reg;
    gml_pkg::out_item_t out_reg;
    gml_pkg::exp_req_t  ereq;
    gml_pkg::exp_rsp_t  ersp;

    logic [NW-1:0] g_use;
    logic [EW-1:0] d_use;
    logic [AW-1:0] rd_addr;
    logic [16:0]   diff;
    logic [16:0]   mag;
    logic [65:0]   mac_p;
    logic [48:0]   nd;
    logic          nd_sat;
    logic [64:0]   nsum;
    logic          load_ok;

    always_comb
    begin
        if (gcfg_reg == 4'd0)
            g_use = NW'(1);
        else if (32'(gcfg_reg) > MAX_COMPONENTS)
            g_use = NW'(MAX_COMPONENTS);
        else
            g_use = NW'(gcfg_reg);
        if (dcfg_reg == 5'd0)
            d_use = EW'(1);
        else if (32'(dcfg_reg) > MAX_DIMS)
            d_use = EW'(MAX_DIMS);
        else
            d_use = EW'(dcfg_reg);
    end

    assign rd_addr = AW'(32'(comp_reg[CW-1:0]) * MAX_DIMS + 32'(count_reg));
    assign diff    = {mean_rd[15], mean_rd} - {item_reg.sample[15], item_reg.sample};
    assign mag     = diff[16] ? (17'd0 - diff) : diff;
    assign mac_p   = {34'd0, ivar_rd} * {32'd0, sq_reg};
    assign nd      = {1'b0, dist_reg[comp_reg[CW-1:0]]} + {1'b0, mac_p[51:4]};
    assign nd_sat  = nd[48] || (mac_p[65:52] != 14'd0);
    assign nsum    = {1'b0, sum_reg} + {1'b0, ersp.term};
    assign load_ok = (32'(item_reg.component) < MAX_COMPONENTS) &&
                     (32'(item_reg.dimension) < MAX_DIMS);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gcfg_reg <= 4'd8;
            dcfg_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            if (cfg_index == gml_pkg::REG_GAUSSIANS)
                gcfg_reg <= cfg_data[3:0];
            else if (cfg_index == gml_pkg::REG_DIMS)
                dcfg_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = in_data.mode ? S_READ : S_LOAD;
            end
            S_LOAD: state_next = S_IDLE;
            S_READ: state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:
            begin
                if (comp_reg + NW'(1) < g_use)
                    state_next = S_READ;
                else if (count_reg + EW'(1) < d_use)
                    state_next = S_IDLE;
                else
                    state_next = S_EXP;
            end
            S_EXP:  state_next = S_WAIT;
            S_WAIT:
            begin
                if (ersp.done)
                    state_next = (comp_reg + NW'(1) < g_use) ? S_EXP : S_OUT;
            end
            S_OUT:  if (!out_valid_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            comp_reg      <= '0;
            sat_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_COMPONENTS; i++)
                dist_reg[i] <= 48'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: comp_reg <= '0;
                S_ACC:
                begin
                    if (nd_sat)
                    begin
                        dist_reg[comp_reg[CW-1:0]] <= gml_pkg::DIST_MAX;
                        sat_reg[comp_reg[CW-1:0]]  <= 1'b1;
                    end
                    else
                        dist_reg[comp_reg[CW-1:0]] <= nd[47:0];
                    if (comp_reg + NW'(1) < g_use)
                        comp_reg <= comp_reg + NW'(1);
                    else if (count_reg + EW'(1) < d_use)
                        count_reg <= count_reg + EW'(1);
                    else
                        comp_reg <= '0;
                end
                S_WAIT:
                begin
                    if (ersp.done)
                        comp_reg <= comp_reg + NW'(1);
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        count_reg     <= '0;
                        sat_reg       <= '0;
                        for (int i = 0; i < MAX_COMPONENTS; i++)
                            dist_reg[i] <= 48'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            item_reg <= in_data;
        if (state_reg == S_LOAD && load_ok)
        begin
            mean_mem[AW'(32'(item_reg.component) * MAX_DIMS + 32'(item_reg.dimension))]
                <= item_reg.mean_value;
            ivar_mem[AW'(32'(item_reg.component) * MAX_DIMS + 32'(item_reg.dimension))]
                <= item_reg.inverse_variance;
            if (item_reg.dimension == 4'd0)
                wt_mem[CW'(item_reg.component)] <= item_reg.mix_weight;
        end
        mean_rd <= mean_mem[rd_addr];
        ivar_rd <= ivar_mem[rd_addr];
        wt_rd   <= wt_mem[comp_reg[CW-1:0]];
        if (state_reg == S_MUL)
            sq_reg <= 34'(mag * mag);
        if (state_reg == S_EXP && comp_reg == '0)
        begin
            sum_reg <= 64'd0;
            ovf_reg <= 1'b0;
        end
        if (state_reg == S_WAIT && ersp.done)
        begin
            if (nsum[64])
                sum_reg <= 64'hFFFF_FFFF_FFFF_FFFF;
            else
                sum_reg <= nsum[63:0];
            ovf_reg <= ovf_reg | nsum[64] | sat_reg[comp_reg[CW-1:0]];
        end
        if (state_reg == S_OUT && !out_valid_reg)
        begin
            out_reg.likelihood <= sum_reg;
            out_reg.overflow   <= ovf_reg;
        end
    end

    assign ereq.start    = (state_reg == S_EXP);
    assign ereq.weight   = wt_rd;
    assign ereq.distance = dist_reg[comp_reg[CW-1:0]];

    gml_exp u_exp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ereq),
        .rsp   (ersp)
    );

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> (comp_reg < g_use)) else $error("component out of range");
`endif

endmodule

// ===== design/gml_exp.sv =====
// ============================================================================
// gml_exp
// Weighted exp(-d/2) term by sequenced multiplies and reciprocal division.
// ============================================================================
module gml_exp
(
    input  logic              clk,
    input  logic              rst_n,
    input  gml_pkg::exp_req_t req,
    output gml_pkg::exp_rsp_t rsp
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_Y    = 7'b0000010,
        S_T    = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_W    = 7'b0100000,
        S_SH   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [47:0] dist_reg;
    logic [31:0] weight_reg;
    logic [31:0] f_reg;
    logic [6:0]  n_reg;
    logic [31:0] t_reg;
    logic [32:0] r_reg;
    logic [3:0]  k_reg;
    logic [32:0] prod_reg;
    logic [63:0] term_reg;
    logic        zero_reg;
    logic        done_reg;

    logic [79:0] y_full;
    logic [63:0] t_full;
    logic [64:0] tr_full;
    logic [63:0] w_full;
    logic [32:0] recip;
    logic [5:0]  rshift;
    logic [65:0] q_full;
    logic [65:0] q_shift;

    assign y_full  = {32'd0, dist_reg} * {48'd0, gml_pkg::LOG2E_Q24};
    assign t_full  = {32'd0, f_reg} * {32'd0, gml_pkg::LN2_Q32};
    assign tr_full = {33'd0, t_reg} * {32'd0, r_reg};
    assign w_full  = {32'd0, weight_reg} * {31'd0, r_reg};
    assign q_full  = {33'd0, prod_reg} * {33'd0, recip};
    assign q_shift = q_full >> rshift;

    always_comb
    begin
        case (k_reg)
            4'd2:    begin recip = 33'h1_0000_0000; rshift = 6'd33; end
            4'd3:    begin recip = 33'h1_5555_5556; rshift = 6'd34; end
            4'd4:    begin recip = 33'h1_0000_0000; rshift = 6'd34; end
            4'd5:    begin recip = 33'h1_9999_999A; rshift = 6'd35; end
            4'd6:    begin recip = 33'h1_5555_5556; rshift = 6'd35; end
            4'd7:    begin recip = 33'h1_2492_4925; rshift = 6'd35; end
            4'd8:    begin recip = 33'h1_0000_0000; rshift = 6'd35; end
            4'd9:    begin recip = 33'h1_C71C_71C8; rshift = 6'd36; end
            4'd10:   begin recip = 33'h1_9999_999A; rshift = 6'd36; end
            4'd11:   begin recip = 33'h1_745D_1746; rshift = 6'd36; end
            4'd12:   begin recip = 33'h1_5555_5556; rshift = 6'd36; end
            default: begin recip = 33'h1_0000_0000; rshift = 6'd32; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_SH) ||
                         (state_reg == S_Y && dist_reg[47:39] != 9'd0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req.start) state_next = S_Y;
            S_Y:    state_next = (dist_reg[47:39] != 9'd0) ? S_IDLE : S_T;
            S_T:    state_next = S_MUL;
            S_MUL:  state_next = S_DIV;
            S_DIV:  state_next = (k_reg == 4'd1) ? S_W : S_MUL;
            S_W:    state_next = S_SH;
            S_SH:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dist_reg   <= req.distance;
                weight_reg <= req.weight;
            end
            S_Y:
            begin
                weight_reg <= req.weight;
                f_reg <= y_full[56:25];
                n_reg <= (y_full[79:63] != 17'd0) ? 7'd64 : {1'b0, y_full[62:57]};
            end
            S_T:
            begin
                t_reg <= t_full[63:32];
                r_reg <= 33'h1_0000_0000;
                k_reg <= 4'(gml_pkg::TAYLOR_DEGREE);
            end
            S_MUL:
            begin
                prod_reg <= tr_full[64:32];
            end
            S_DIV:
            begin
                r_reg <= 33'h1_0000_0000 - q_shift[32:0];
                k_reg <= k_reg - 4'd1;
            end
            S_W:
            begin
                term_reg <= w_full;
                zero_reg <= n_reg[6];
            end
            S_SH:
            begin
                term_reg <= zero_reg ? 64'd0 : (term_reg >> n_reg[5:0]);
            end
            default: ;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.term = (dist_reg[47:39] != 9'd0) ? 64'd0 : term_reg;

endmodule

// ===== test/tb_top.sv =====
// ============================================================================
// tb_top
// Testbench of the Gaussian mixture likelihood scorer: loads the whole model,
// runs a directed table and randomized phases under several register
// settings and idle patterns, and compares every likelihood and overflow result
// with a predictor of the block's fixed-point scoring or a directed row's value.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        gml_pkg::in_item_t  item;
        bit                 has_want;
        gml_pkg::out_item_t want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    gml_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    gml_pkg::out_item_t out_data;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = gml_pkg::REG_GAUSSIANS;
    logic [4:0]         cfg_data = '0;

    bit                 fix_en = 1'b0;
    gml_pkg::out_item_t fix_val = '0;
    int                 in_idle_pct = 37;
    int                 out_idle_pct = 57;
    int                 mismatches = 0;

    gml_pkg::out_item_t likelihood_q[$];
    logic signed [15:0] mean_mem[8][16];
    logic [31:0]        ivar_mem[8][16];
    logic [31:0]        wt_mem[8];
    logic [47:0]        dist_acc[8];
    bit                 dist_sat[8];
    int                 elem_cnt = 0;
    logic [3:0]         g_reg = 4'd8;
    logic [4:0]         d_reg = 5'd16;

    gaussian_mixture_likelihood u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] exp_term(logic [31:0] w, logic [47:0] d);
        logic [63:0] y;
        logic [63:0] f;
        logic [63:0] t;
        logic [63:0] r;
        int          n;
        if (64'(d) >= (64'd1 << 39))
            return 64'd0;
        y = (64'(d) * 64'(gml_pkg::LOG2E_Q24)) >> 25;
        n = int'(y >> 32);
        f = y & 64'hFFFF_FFFF;
        t = (f * 64'(gml_pkg::LN2_Q32)) >> 32;
        r = 64'd1 << 32;
        for (int k = gml_pkg::TAYLOR_DEGREE; k >= 1; k--)
            r = (64'd1 << 32) - ((t * r) >> 32) / 64'(k);
        if (n >= 64)
            return 64'd0;
        return (64'(w) * r) >> n;
    endfunction

    function automatic int clamp_count(int v, int hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic void score_item(gml_pkg::in_item_t it, bit has_want,
                                       gml_pkg::out_item_t want);
        int                 g;
        int                 dn;
        longint             diff;
        longint             mag;
        logic [63:0]        inc;
        logic [63:0]        nd;
        logic [63:0]        sum;
        logic [64:0]        s;
        bit                 ovf;
        gml_pkg::out_item_t res;
        if (!it.mode)
        begin
            mean_mem[it.component][it.dimension] = it.mean_value;
            ivar_mem[it.component][it.dimension] = it.inverse_variance;
            if (it.dimension == 4'd0)
                wt_mem[it.component] = it.mix_weight;
            return;
        end
        g = clamp_count(int'(g_reg), 8);
        dn = clamp_count(int'(d_reg), 16);
        for (int k = 0; k < g; k++)
        begin
            diff = longint'(mean_mem[k][elem_cnt]) - longint'(it.sample);
            mag = (diff < 0) ? -diff : diff;
            inc = (64'(ivar_mem[k][elem_cnt]) * 64'(mag * mag)) >> 4;
            nd = 64'(dist_acc[k]) + inc;
            if (nd > 64'(gml_pkg::DIST_MAX))
            begin
                nd = 64'(gml_pkg::DIST_MAX);
                dist_sat[k] = 1'b1;
            end
            dist_acc[k] = nd[47:0];
        end
        if (elem_cnt + 1 < dn)
        begin
            elem_cnt++;
            return;
        end
        sum = '0;
        ovf = 1'b0;
        for (int k = 0; k < g; k++)
        begin
            if (dist_sat[k])
                ovf = 1'b1;
            s = 65'(sum) + 65'(exp_term(wt_mem[k], dist_acc[k]));
            if (s[64])
            begin
                sum = '1;
                ovf = 1'b1;
            end
            else
                sum = s[63:0];
        end
        for (int k = 0; k < 8; k++)
        begin
            dist_acc[k] = '0;
            dist_sat[k] = 1'b0;
        end
        elem_cnt = 0;
        res.likelihood = sum;
        res.overflow = ovf;
        likelihood_q.push_back(has_want ? want : res);
    endfunction

    always @(posedge clk)
    begin
        gml_pkg::out_item_t exp_res;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gml_pkg::REG_GAUSSIANS: g_reg = cfg_data[3:0];
                    gml_pkg::REG_DIMS:      d_reg = cfg_data;
                    default:                ;
                endcase
            end
            if (in_valid && in_ready)
                score_item(in_data, fix_en, fix_val);
            if (out_valid && out_ready)
            begin
                if (likelihood_q.size() == 0)
                    note_mismatch($sformatf("unexpected transfer %h/%b",
                        out_data.likelihood, out_data.overflow));
                else
                begin
                    exp_res = likelihood_q.pop_front();
                    if (out_data.likelihood !== exp_res.likelihood)
                        note_mismatch($sformatf("likelihood exp %h got %h",
                            exp_res.likelihood, out_data.likelihood));
                    if (out_data.overflow !== exp_res.overflow)
                        note_mismatch($sformatf("overflow exp %b got %b",
                            exp_res.overflow, out_data.overflow));
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_idle_pct);

    function automatic logic signed [15:0] near_val();
        if ($urandom_range(99) < 80)
            return 16'(int'($urandom_range(0, 4095)) - 2048);
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] rand_ivar();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return $urandom_range(0, 32'h4000);
        if (pick < 80)
            return $urandom_range(0, 32'h4_0000);
        return $urandom;
    endfunction

    function automatic gml_pkg::in_item_t rand_item(bit is_load);
        gml_pkg::in_item_t it;
        it = '0;
        it.mode = !is_load;
        it.component = 3'($urandom);
        it.dimension = 4'($urandom);
        it.mean_value = near_val();
        it.inverse_variance = rand_ivar();
        it.mix_weight = $urandom;
        it.sample = near_val();
        return it;
    endfunction

    function automatic dir_row_t mk_load(int c, int d, int m, logic [31:0] iv,
                                         logic [31:0] w);
        dir_row_t row;
        row.item = '0;
        row.item.component = 3'(c);
        row.item.dimension = 4'(d);
        row.item.mean_value = 16'(m);
        row.item.inverse_variance = iv;
        row.item.mix_weight = w;
        row.has_want = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic dir_row_t mk_samp(int x, bit has, logic [63:0] lk, bit ov);
        dir_row_t row;
        row.item = '0;
        row.item.mode = 1'b1;
        row.item.sample = 16'(x);
        row.has_want = has;
        row.want = {lk, ov};
        return row;
    endfunction

    task automatic send(gml_pkg::in_item_t it, bit has_want, gml_pkg::out_item_t want);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        fix_en <= has_want;
        fix_val <= want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (likelihood_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_cfg(int g, int d);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= gml_pkg::REG_GAUSSIANS;
        cfg_data <= 5'(g);
        @(posedge clk);
        cfg_index <= gml_pkg::REG_DIMS;
        cfg_data <= 5'(d);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        #60ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        dir_row_t          dir_tab[];
        gml_pkg::in_item_t it;
        int                g;
        int                d;
        int                waited;
        dir_tab = '{
            mk_load(0, 0, 0, 32'd0, 32'hFFFF_FFFF),
            mk_load(1, 0, 0, 32'd0, 32'hFFFF_FFFF),
            mk_samp(0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1),
            mk_load(0, 0, 32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            mk_samp(-32768, 1'b1, 64'hFFFF_FFFF_0000_0000, 1'b1),
            mk_load(0, 0, -32768, 32'd0, 32'd0),
            mk_load(1, 0, 0, 32'd0, 32'd0),
            mk_samp(32767, 1'b1, 64'd0, 1'b0),
            mk_load(0, 0, 1024, 32'h0001_0000, 32'h0001_0000),
            mk_load(1, 0, -1024, 32'h0000_8000, 32'h8000_0000),
            mk_samp(0, 1'b0, 64'd0, 1'b0),
            mk_samp(512, 1'b0, 64'd0, 1'b0),
            mk_samp(-32768, 1'b0, 64'd0, 1'b0),
            mk_load(1, 0, 100, 32'h0000_0100, 32'h0000_0001),
            mk_samp(-100, 1'b0, 64'd0, 1'b0)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int c = 0; c < 8; c++)
        begin
            for (int k = 0; k < 16; k++)
            begin
                it = rand_item(1'b1);
                it.component = 3'(c);
                it.dimension = 4'(k);
                send(it, 1'b0, '0);
            end
        end
        repeat (32) send(rand_item(1'b0), 1'b0, '0);

        set_cfg(2, 1);
        foreach (dir_tab[i])
            send(dir_tab[i].item, dir_tab[i].has_want, dir_tab[i].want);

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: begin g = 1;  d = 1;  end
                1: begin g = 15; d = 31; end
                2: begin g = 0;  d = 0;  end
                3: begin g = 8;  d = 16; end
                4: begin g = 3;  d = 4;  end
                5: begin g = 8;  d = 1;  end
                default:
                begin
                    g = ($urandom_range(99) < 30) ? $urandom_range(0, 15)
                                                  : $urandom_range(1, 3);
                    d = ($urandom_range(99) < 20) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, 6);
                end
            endcase
            set_cfg(g, d);
            if (p < 4)
            begin
                in_idle_pct = 37;
                out_idle_pct = 57;
            end
            else if (p < 8)
            begin
                in_idle_pct = 57;
                out_idle_pct = 37;
            end
            else
            begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            repeat (45) send(rand_item($urandom_range(99) < 10), 1'b0, '0);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (likelihood_q.size() != 0 && waited < 2000000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (mismatches == 0 && likelihood_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gml_pkg.sv
design/gml_exp.sv
design/gaussian_mixture_likelihood.sv
test/tb_top.sv
